FILE: hdl/fgov_pkg.sv
// ----------------------------------------------------------------------------
// fgov_pkg
// shared types, codes and fixed-point constants of the frame time governor
// ----------------------------------------------------------------------------
package fgov_pkg;

	localparam int TIME_FRAC_BITS  = 8;
	localparam int SCALE_FRAC_BITS = 10;

	localparam int TIME_W   = 16;
	localparam int ALPHA_W  = SCALE_FRAC_BITS + 1;
	localparam int SCALE_W  = SCALE_FRAC_BITS + 1;
	localparam int FPS_W    = 8;
	localparam int RATIO_W  = 10;
	localparam int HOLD_W   = 24;
	localparam int DELTA_W  = 20;
	localparam int PROD_W   = TIME_W + ALPHA_W;
	localparam int MPROD_W  = TIME_W + FPS_W;
	localparam int CNT_W    = 8;
	localparam int STEP_W   = 4;
	localparam int NUM_AVG  = 7;
	localparam int AIDX_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// average slots
	localparam logic [AIDX_W-1:0] AVG_FRAME = 3'd0;
	localparam logic [AIDX_W-1:0] AVG_CPU   = 3'd1;
	localparam logic [AIDX_W-1:0] AVG_GPU   = 3'd2;
	localparam logic [AIDX_W-1:0] AVG_PRE   = 3'd3;
	localparam logic [AIDX_W-1:0] AVG_WORLD = 3'd4;
	localparam logic [AIDX_W-1:0] AVG_COMP  = 3'd5;
	localparam logic [AIDX_W-1:0] AVG_ITV   = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ALPHA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FPS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGRADE_RATIO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_RATIO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGRADE_HOLD    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_HOLD    = 3'd5;

	localparam logic [ALPHA_W-1:0] RST_ALPHA        = 11'd102;
	localparam logic [FPS_W-1:0]   RST_FPS          = 8'd60;
	localparam logic [RATIO_W-1:0] RST_DEGRADE      = 10'd269;
	localparam logic [RATIO_W-1:0] RST_RECOVER      = 10'd218;
	localparam logic [HOLD_W-1:0]  RST_DEGRADE_HOLD = 24'd500000;
	localparam logic [HOLD_W-1:0]  RST_RECOVER_HOLD = 24'd2000000;

	// bottleneck classes
	localparam logic [2:0] CLS_BALANCED = 3'd0;
	localparam logic [2:0] CLS_GPU      = 3'd1;
	localparam logic [2:0] CLS_CPU      = 3'd2;
	localparam logic [2:0] CLS_PACED    = 3'd3;
	localparam logic [2:0] CLS_THERMAL  = 3'd4;

	// pass classes
	localparam logic [1:0] PASS_BALANCED = 2'd0;
	localparam logic [1:0] PASS_PRE      = 2'd1;
	localparam logic [1:0] PASS_WORLD    = 2'd2;
	localparam logic [1:0] PASS_COMP     = 2'd3;

	// thermal codes
	localparam logic [2:0] TH_NOMINAL  = 3'd0;
	localparam logic [2:0] TH_LIGHT    = 3'd1;
	localparam logic [2:0] TH_MODERATE = 3'd2;
	localparam logic [2:0] TH_SEVERE   = 3'd3;
	localparam logic [2:0] TH_CRITICAL = 3'd4;

	localparam logic [1:0] LVL_LOW    = 2'd0;
	localparam logic [1:0] LVL_MEDIUM = 2'd1;
	localparam logic [1:0] LVL_HIGH   = 2'd2;
	localparam logic [1:0] LVL_ULTRA  = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
	localparam logic [DELTA_W-1:0] DELTA_MAX = 20'd250000;

	// one second in time units, and fixed fractions of it
	localparam int ONE_SEC = 1000 << TIME_FRAC_BITS;
	localparam logic [MPROD_W-1:0] T_92  = MPROD_W'(ONE_SEC * 92 / 100);
	localparam logic [MPROD_W-1:0] T_108 = MPROD_W'(ONE_SEC * 108 / 100);
	localparam logic [MPROD_W-1:0] T_82  = MPROD_W'(ONE_SEC * 82 / 100);

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << SCALE_FRAC_BITS);
	localparam logic [ALPHA_W-1:0] ALPHA_MIN = ALPHA_W'(1);
	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1 << (SCALE_FRAC_BITS - 1));

	localparam int SC_ONE_I = 1 << SCALE_FRAC_BITS;
	localparam int SC_90_I  = ((90 << SCALE_FRAC_BITS) + 50) / 100;
	localparam int SC_94_I  = ((94 << SCALE_FRAC_BITS) + 50) / 100;
	localparam int SC_97_I  = ((97 << SCALE_FRAC_BITS) + 50) / 100;
	localparam int SC_60_I  = ((60 << SCALE_FRAC_BITS) + 50) / 100;
	localparam int SC_84_I  = ((84 << SCALE_FRAC_BITS) + 50) / 100;
	localparam int SC_78_I  = ((78 << SCALE_FRAC_BITS) + 50) / 100;

	localparam logic [SCALE_W-1:0] SC_ONE = SCALE_W'(SC_ONE_I);
	localparam logic [SCALE_W-1:0] SC_90  = SCALE_W'(SC_90_I);
	localparam logic [SCALE_W-1:0] SC_94  = SCALE_W'(SC_94_I);
	localparam logic [SCALE_W-1:0] SC_97  = SCALE_W'(SC_97_I);
	localparam logic [SCALE_W-1:0] SC_60  = SCALE_W'(SC_60_I);
	localparam logic [SCALE_W-1:0] SC_84  = SCALE_W'(SC_84_I);
	localparam logic [SCALE_W-1:0] SC_78  = SCALE_W'(SC_78_I);

	// composite trim of each level scale
	localparam logic [SCALE_W-1:0] TR_LOW    = SCALE_W'((SC_90_I * 9 + 5) / 10);
	localparam logic [SCALE_W-1:0] TR_MEDIUM = SCALE_W'((SC_94_I * 9 + 5) / 10);
	localparam logic [SCALE_W-1:0] TR_HIGH   = SCALE_W'((SC_97_I * 9 + 5) / 10);
	localparam logic [SCALE_W-1:0] TR_ULTRA  = SCALE_W'((SC_ONE_I * 9 + 5) / 10);

	localparam logic [STEP_W-1:0] SMOOTH_LAST = STEP_W'(2 * NUM_AVG - 1);
	localparam logic [STEP_W-1:0] MUL_LAST    = STEP_W'(3);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_MUL,
		ST_FLAG,
		ST_UPD
	} fgov_state_t;

	typedef struct packed {
		logic              load;
		logic              smooth_en;
		logic              mul_en;
		logic              flag_en;
		logic              upd_en;
		logic [STEP_W-1:0] step;
	} fgov_cmd_t;

endpackage

FILE: hdl/fgov_ctrl.sv
// ----------------------------------------------------------------------------
// fgov_ctrl
// sequencer: request intake, smoothing, multiply and compare steps, update and result handoff
// ----------------------------------------------------------------------------
module fgov_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output fgov_pkg::fgov_cmd_t cmd
);
	import fgov_pkg::*;

	fgov_state_t       state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.step = cnt_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SMOOTH;
					cnt_d    = '0;
				end
			end
			ST_SMOOTH: begin
				cmd.smooth_en = 1'b1;
				if (cnt_q == SMOOTH_LAST) begin
					state_d = ST_MUL;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (cnt_q == MUL_LAST) begin
					state_d = ST_FLAG;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			ST_FLAG: begin
				cmd.flag_en = 1'b1;
				state_d     = ST_UPD;
			end
			ST_UPD: begin
				if (!out_valid_q || out_ready) begin
					cmd.upd_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		out_valid_d = cmd.upd_en || (out_valid_q && !out_ready);
	end

	assign out_valid = out_valid_q;

	a_upd_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_en |=> out_valid_q)
		else $error("result not presented after update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_en |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_smooth_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SMOOTH && cnt_q == SMOOTH_LAST) |=>
		(state_q == ST_MUL && cnt_q == '0))
		else $error("smoothing sequence did not hand over");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_SMOOTH && cnt_q == '0))
		else $error("request did not start smoothing");

endmodule

FILE: hdl/fgov_dp.sv
// ----------------------------------------------------------------------------
// fgov_dp
// datapath: registers, shared multiplier, averages, classes, hold timers, scale
// ----------------------------------------------------------------------------
module fgov_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fgov_pkg::fgov_cmd_t                  cmd,
	input  logic                                 cfg_we,
	input  logic [fgov_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fgov_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [fgov_pkg::TIME_W-1:0]          cpu_ms,
	input  logic [fgov_pkg::TIME_W-1:0]          gpu_ms,
	input  logic [fgov_pkg::TIME_W-1:0]          pre_world_ms,
	input  logic [fgov_pkg::TIME_W-1:0]          world_ms,
	input  logic [fgov_pkg::TIME_W-1:0]          composite_ms,
	input  logic [fgov_pkg::TIME_W-1:0]          interval_ms,
	input  logic                                 pass_timing_valid,
	input  logic [2:0]                           thermal,
	input  logic [fgov_pkg::DELTA_W-1:0]         delta_us,
	output logic [1:0]                           quality_level,
	output logic [2:0]                           bottleneck_class,
	output logic [1:0]                           pass_class,
	output logic [fgov_pkg::SCALE_W-1:0]         render_scale
);
	import fgov_pkg::*;

	// configuration
	logic [ALPHA_W-1:0] alpha_q;
	logic [FPS_W-1:0]   fps_q;
	logic [RATIO_W-1:0] degrade_q, recover_q;
	logic [HOLD_W-1:0]  degrade_hold_q, recover_hold_q;

	// latched request
	logic [TIME_W-1:0]  x_q [NUM_AVG];
	logic               pvalid_q;
	logic [2:0]         th_q;
	logic [DELTA_W-1:0] dt_q;

	// state
	logic [TIME_W-1:0]  avg_q [NUM_AVG];
	logic [1:0]         level_q;
	logic [2:0]         class_now_q, class_pend_q;
	logic [CNT_W-1:0]   class_hold_q, pass_hold_q;
	logic [1:0]         pass_now_q, pass_pend_q;
	logic [HOLD_W-1:0]  over_time_q, rec_time_q;

	// work registers
	logic [PROD_W-1:0]  acc_q;
	logic [MPROD_W-1:0] m_q [4];
	logic [2:0]         cand_q;
	logic [1:0]         pc_q;
	logic               auth_q, over_q, rec_q;

	// output registers
	logic [1:0]         level_out_q, pass_out_q;
	logic [2:0]         class_out_q;
	logic [SCALE_W-1:0] scale_out_q;

	logic [ALPHA_W-1:0] a_eff, a_inv;
	logic [FPS_W-1:0]   fps_eff;
	logic [AIDX_W-1:0]  k;
	logic [TIME_W-1:0]  mul_a, x_sel, avg_sel, avg_new;
	logic [ALPHA_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W:0]    sum;
	logic               x_en;

	always_comb begin
		if (alpha_q == '0) a_eff = ALPHA_MIN;
		else if (alpha_q > ALPHA_ONE) a_eff = ALPHA_ONE;
		else a_eff = alpha_q;
		a_inv   = ALPHA_ONE - a_eff;
		fps_eff = (fps_q == '0) ? FPS_W'(1) : fps_q;
		k       = cmd.step[AIDX_W:1];
		x_sel   = x_q[k];
		avg_sel = avg_q[k];
		x_en    = (x_sel != '0) &&
			(pvalid_q || !(k == AVG_PRE || k == AVG_WORLD || k == AVG_COMP));
		if (cmd.mul_en) begin
			case (cmd.step[1:0])
				2'd0:    mul_a = avg_q[AVG_CPU];
				2'd1:    mul_a = avg_q[AVG_GPU];
				2'd2:    mul_a = avg_q[AVG_ITV];
				default: mul_a = avg_q[AVG_FRAME];
			endcase
			mul_b = ALPHA_W'(fps_eff);
		end else if (cmd.step[0]) begin
			mul_a = x_sel;
			mul_b = a_eff;
		end else begin
			mul_a = avg_sel;
			mul_b = a_inv;
		end
		prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
		sum     = (PROD_W+1)'(acc_q) + (PROD_W+1)'(prod) + ROUND_HALF;
		avg_new = sum[SCALE_FRAC_BITS +: TIME_W];
	end

	// flag stage
	logic              cv, gv, cp, gp, auth;
	logic [TIME_W+3:0] cpu10, cpu11, gpu10, gpu11;
	logic [TIME_W-1:0] p0, p1, p2, big, second;
	logic [2:0]        cand;
	logic [1:0]        pc;
	logic [MPROD_W+7:0] m_frame_sh;
	logic [MPROD_W+7:0] lim_deg, lim_rec;

	always_comb begin
		cv    = avg_q[AVG_CPU] != '0;
		gv    = avg_q[AVG_GPU] != '0;
		cp    = cv && (m_q[0] > T_92);
		gp    = gv && (m_q[1] > T_92);
		cpu10 = (TIME_W+4)'(avg_q[AVG_CPU]) * (TIME_W+4)'(10);
		cpu11 = (TIME_W+4)'(avg_q[AVG_CPU]) * (TIME_W+4)'(11);
		gpu10 = (TIME_W+4)'(avg_q[AVG_GPU]) * (TIME_W+4)'(10);
		gpu11 = (TIME_W+4)'(avg_q[AVG_GPU]) * (TIME_W+4)'(11);
		if (th_q >= TH_SEVERE) cand = CLS_THERMAL;
		else if (gp && (!cp || gpu10 > cpu11)) cand = CLS_GPU;
		else if (cp && (!gp || cpu10 > gpu11)) cand = CLS_CPU;
		else if (avg_q[AVG_ITV] != '0 && m_q[2] > T_108 &&
			(!cv || m_q[0] < T_82) && (!gv || m_q[1] < T_82)) cand = CLS_PACED;
		else cand = CLS_BALANCED;

		auth = pvalid_q && gv;
		p0   = avg_q[AVG_PRE];
		p1   = avg_q[AVG_WORLD];
		p2   = avg_q[AVG_COMP];
		if (p0 >= p1 && p0 >= p2) begin
			big    = p0;
			second = (p1 > p2) ? p1 : p2;
		end else if (p1 >= p2) begin
			big    = p1;
			second = (p0 > p2) ? p0 : p2;
		end else begin
			big    = p2;
			second = (p0 > p1) ? p0 : p1;
		end
		pc = PASS_BALANCED;
		if (auth && gp) begin
			if ((TIME_W+5)'(big) * (TIME_W+5)'(25) > (TIME_W+5)'(second) * (TIME_W+5)'(28) ||
				{big, 1'b0} > {1'b0, avg_q[AVG_GPU]}) begin
				if (big == p0) pc = PASS_PRE;
				else if (big == p1) pc = PASS_WORLD;
				else pc = PASS_COMP;
			end
		end
		m_frame_sh = {m_q[3], 8'b0};
		lim_deg    = (MPROD_W+8)'(ONE_SEC) * (MPROD_W+8)'(degrade_q);
		lim_rec    = (MPROD_W+8)'(ONE_SEC) * (MPROD_W+8)'(recover_q);
	end

	// update stage
	logic [DELTA_W-1:0] dt;
	logic [CNT_W-1:0]   ch_n, ph_n;
	logic [2:0]         cnow_n, cpend_n;
	logic [1:0]         pnow_n, ppend_n, lvl_n;
	logic [HOLD_W:0]    ov_sum, rc_sum;
	logic [HOLD_W-1:0]  ov_n, rc_n, dt_ext;
	logic [SCALE_W-1:0] scale, trim;
	logic [CNT_W+2:0]   ch5, ph5;

	always_comb begin
		dt     = (dt_q > DELTA_MAX) ? DELTA_MAX : dt_q;
		dt_ext = HOLD_W'(dt);

		if (cand_q == class_pend_q) begin
			cpend_n = class_pend_q;
			ch_n    = (class_hold_q < CNT_MAX) ? class_hold_q + CNT_W'(1) : class_hold_q;
		end else begin
			cpend_n = cand_q;
			ch_n    = '0;
		end
		ch5    = (CNT_W+3)'(ch_n) * (CNT_W+3)'(5);
		cnow_n = (cand_q == CLS_THERMAL || ch5 >= (CNT_W+3)'(fps_eff)) ? cand_q : class_now_q;

		if (pc_q == pass_pend_q) begin
			ppend_n = pass_pend_q;
			ph_n    = (pass_hold_q < CNT_MAX) ? pass_hold_q + CNT_W'(1) : pass_hold_q;
		end else begin
			ppend_n = pc_q;
			ph_n    = '0;
		end
		ph5    = (CNT_W+3)'(ph_n) * (CNT_W+3)'(5);
		pnow_n = pass_now_q;
		if (!auth_q) begin
			pnow_n  = PASS_BALANCED;
			ppend_n = PASS_BALANCED;
			ph_n    = '0;
		end else if (ph5 >= (CNT_W+3)'(fps_eff)) begin
			pnow_n = pc_q;
		end

		ov_sum = (HOLD_W+1)'(over_time_q) + (HOLD_W+1)'(dt_ext);
		rc_sum = (HOLD_W+1)'(rec_time_q) + (HOLD_W+1)'(dt_ext);
		if (over_q) begin
			ov_n = ov_sum[HOLD_W] ? HOLD_MAX : ov_sum[HOLD_W-1:0];
			rc_n = '0;
		end else if (rec_q) begin
			rc_n = rc_sum[HOLD_W] ? HOLD_MAX : rc_sum[HOLD_W-1:0];
			ov_n = '0;
		end else begin
			ov_n = (over_time_q > dt_ext) ? over_time_q - dt_ext : '0;
			rc_n = (rec_time_q > dt_ext) ? rec_time_q - dt_ext : '0;
		end
		lvl_n = level_q;
		if (ov_n >= degrade_hold_q) begin
			if (lvl_n != LVL_LOW) lvl_n = lvl_n - 2'd1;
			ov_n = '0;
			rc_n = '0;
		end else if (rc_n >= recover_hold_q) begin
			if (lvl_n != LVL_ULTRA) lvl_n = lvl_n + 2'd1;
			rc_n = '0;
		end
		if (th_q == TH_MODERATE && lvl_n > LVL_HIGH) lvl_n = LVL_HIGH;
		else if (th_q == TH_SEVERE && lvl_n > LVL_MEDIUM) lvl_n = LVL_MEDIUM;
		else if (th_q == TH_CRITICAL) lvl_n = LVL_LOW;

		case (lvl_n)
			LVL_LOW: begin
				scale = SC_90;
				trim  = TR_LOW;
			end
			LVL_MEDIUM: begin
				scale = SC_94;
				trim  = TR_MEDIUM;
			end
			LVL_HIGH: begin
				scale = SC_97;
				trim  = TR_HIGH;
			end
			default: begin
				scale = SC_ONE;
				trim  = TR_ULTRA;
			end
		endcase
		if (cnow_n == CLS_GPU && pnow_n == PASS_COMP) scale = (trim < SC_60) ? SC_60 : trim;
		if (th_q <= TH_LIGHT) begin
			if (scale < SC_90) scale = SC_90;
		end else if (th_q == TH_MODERATE) begin
			if (scale > SC_90) scale = SC_90;
		end else if (th_q == TH_SEVERE) begin
			if (scale > SC_84) scale = SC_84;
		end else begin
			if (scale > SC_78) scale = SC_78;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q        <= RST_ALPHA;
			fps_q          <= RST_FPS;
			degrade_q      <= RST_DEGRADE;
			recover_q      <= RST_RECOVER;
			degrade_hold_q <= RST_DEGRADE_HOLD;
			recover_hold_q <= RST_RECOVER_HOLD;
			for (int i = 0; i < NUM_AVG; i++) avg_q[i] <= '0;
			level_q      <= LVL_HIGH;
			class_now_q  <= CLS_BALANCED;
			class_pend_q <= CLS_BALANCED;
			class_hold_q <= '0;
			pass_now_q   <= PASS_BALANCED;
			pass_pend_q  <= PASS_BALANCED;
			pass_hold_q  <= '0;
			over_time_q  <= '0;
			rec_time_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SMOOTHING_ALPHA: alpha_q        <= cfg_data[ALPHA_W-1:0];
					CFG_TARGET_FPS:      fps_q          <= cfg_data[FPS_W-1:0];
					CFG_DEGRADE_RATIO:   degrade_q      <= cfg_data[RATIO_W-1:0];
					CFG_RECOVER_RATIO:   recover_q      <= cfg_data[RATIO_W-1:0];
					CFG_DEGRADE_HOLD:    degrade_hold_q <= cfg_data[HOLD_W-1:0];
					CFG_RECOVER_HOLD:    recover_hold_q <= cfg_data[HOLD_W-1:0];
					default: ;
				endcase
			end
			if (cmd.smooth_en && cmd.step[0] && x_en)
				avg_q[k] <= (avg_sel == '0) ? x_sel : avg_new;
			if (cmd.upd_en) begin
				level_q      <= lvl_n;
				class_now_q  <= cnow_n;
				class_pend_q <= cpend_n;
				class_hold_q <= ch_n;
				pass_now_q   <= pnow_n;
				pass_pend_q  <= ppend_n;
				pass_hold_q  <= ph_n;
				over_time_q  <= ov_n;
				rec_time_q   <= rc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q[AVG_FRAME] <= (cpu_ms > gpu_ms) ? cpu_ms : gpu_ms;
			x_q[AVG_CPU]   <= cpu_ms;
			x_q[AVG_GPU]   <= gpu_ms;
			x_q[AVG_PRE]   <= pre_world_ms;
			x_q[AVG_WORLD] <= world_ms;
			x_q[AVG_COMP]  <= composite_ms;
			x_q[AVG_ITV]   <= interval_ms;
			pvalid_q       <= pass_timing_valid;
			th_q           <= (thermal > TH_CRITICAL) ? TH_CRITICAL : thermal;
			dt_q           <= delta_us;
		end
		if (cmd.smooth_en && !cmd.step[0]) acc_q <= prod;
		if (cmd.mul_en) m_q[cmd.step[1:0]] <= prod[MPROD_W-1:0];
		if (cmd.flag_en) begin
			cand_q <= cand;
			pc_q   <= pc;
			auth_q <= auth;
			over_q <= m_frame_sh > lim_deg;
			rec_q  <= (avg_q[AVG_FRAME] != '0) && (m_frame_sh < lim_rec);
		end
		if (cmd.upd_en) begin
			level_out_q <= lvl_n;
			class_out_q <= cnow_n;
			pass_out_q  <= pnow_n;
			scale_out_q <= scale;
		end
	end

	assign quality_level    = level_out_q;
	assign bottleneck_class = class_out_q;
	assign pass_class       = pass_out_q;
	assign render_scale     = scale_out_q;

	a_thermal_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd_en && th_q == TH_CRITICAL) |=> (level_q == LVL_LOW))
		else $error("critical thermal did not force lowest level");

	a_thermal_class: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd_en && cand_q == CLS_THERMAL) |=> (class_now_q == CLS_THERMAL))
		else $error("thermal class not taken at once");

	a_no_auth_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd_en && !auth_q) |=> (pass_now_q == PASS_BALANCED && pass_hold_q == '0))
		else $error("pass class kept without authoritative timings");

endmodule

FILE: hdl/frame_time_quality_governor_unit.sv
// ----------------------------------------------------------------------------
// frame_time_quality_governor_unit
// frame timing governor: smoothed timings to quality level, classes and scale
// ----------------------------------------------------------------------------
// requests are handled one at a time; the next is taken only after the update step
// of the last, and the pace is set by the single shared multiplier
//   (two products per average for seven averages, then four period products)
// a new request is taken while the previous result waits at the output
// reset: asynchronous, restores register defaults, clears averages and timers
module frame_time_quality_governor_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cpu_ms, gpu_ms, pre_world_ms, world_ms, composite_ms, interval_ms,
	// thermal, delta_us, zero pad
	input  logic [119:0] s_axis_tdata,
	// pass_timing_valid
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// quality_level, bottleneck_class, pass_class, render_scale, zero pad
	output logic [23:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [fgov_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fgov_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fgov_pkg::*;

	fgov_cmd_t          cmd;
	logic [1:0]         quality_level, pass_class;
	logic [2:0]         bottleneck_class;
	logic [SCALE_W-1:0] render_scale;

	assign cfg_ready = 1'b1;

	fgov_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	fgov_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.cpu_ms            (s_axis_tdata[15:0]),
		.gpu_ms            (s_axis_tdata[31:16]),
		.pre_world_ms      (s_axis_tdata[47:32]),
		.world_ms          (s_axis_tdata[63:48]),
		.composite_ms      (s_axis_tdata[79:64]),
		.interval_ms       (s_axis_tdata[95:80]),
		.pass_timing_valid (s_axis_tuser),
		.thermal           (s_axis_tdata[98:96]),
		.delta_us          (s_axis_tdata[118:99]),
		.quality_level     (quality_level),
		.bottleneck_class  (bottleneck_class),
		.pass_class        (pass_class),
		.render_scale      (render_scale)
	);

	assign m_axis_tdata = {6'b0, render_scale, pass_class, bottleneck_class, quality_level};

endmodule

FILE: tb/sv/frame_time_quality_governor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_quality_governor_unit_tb
// self-checking bench: frame timing requests go in through a bursty driver,
// each accepted request is run through a local governor model, and every
// result is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
module frame_time_quality_governor_unit_tb;
	import fgov_pkg::*;

	typedef enum logic [1:0] {REQ_FRAME, REQ_CFG, REQ_DRAIN} req_kind_t;

	typedef struct {
		req_kind_t       kind;
		logic [15:0]     cpu, gpu, pre, world, comp, itv;
		logic            pvalid;
		logic [2:0]      thermal;
		logic [19:0]     delta;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
	} req_t;

	typedef struct {
		logic [1:0]  level;
		logic [2:0]  bclass;
		logic [1:0]  pclass;
		logic [10:0] scale;
	} gov_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [23:0]  m_axis_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	frame_time_quality_governor_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	req_t        pending_reqs[$];
	gov_result_t expected_results[$];
	req_t        cur_frame, cur_cfg;
	int          n_errors = 0, n_frames = 0, n_results = 0, n_cfg = 0;
	int          quiet_cycles = 0, idle_cycles = 0;
	bit          in_fire = 0, cfg_fire = 0;
	bit          busy = 0;
	int          gap_left = 0, burst_left = 4;
	int          hold_off = 0, hold_done = 0, rx_cycle = 0;

	// governor model state
	logic [63:0] g_alpha, g_fps, g_deg, g_rec, g_dhold, g_rhold;
	logic [63:0] av_frame, av_cpu, av_gpu, av_itv;
	logic [63:0] av_pass[3];
	logic [63:0] over_t, recov_t;
	int          g_level, cls_now, cls_pend, cls_hold, pas_now, pas_pend, pas_hold;

	function automatic logic [63:0] pct(input int p);
		return ((64'(p) << 10) + 50) / 100;
	endfunction

	function automatic logic [63:0] ema(input logic [63:0] x, a, avg);
		if (x == 0) return avg;
		if (avg == 0) return x;
		return (avg * (1024 - a) + x * a + 512) >> 10;
	endfunction

	function automatic bit over_period(input logic [63:0] v, f, num, den);
		return v * f * den > 64'd256000 * num;
	endfunction

	function automatic bit under_period(input logic [63:0] v, f, num, den);
		return v * f * den < 64'd256000 * num;
	endfunction

	function automatic logic [63:0] mx(input logic [63:0] a, b);
		return a > b ? a : b;
	endfunction

	function automatic void gov_reset_model();
		g_alpha = 102; g_fps = 60; g_deg = 269; g_rec = 218;
		g_dhold = 500000; g_rhold = 2000000;
		av_frame = 0; av_cpu = 0; av_gpu = 0; av_itv = 0;
		av_pass[0] = 0; av_pass[1] = 0; av_pass[2] = 0;
		g_level = 2; cls_now = 0; cls_pend = 0; cls_hold = 0;
		pas_now = 0; pas_pend = 0; pas_hold = 0;
		over_t = 0; recov_t = 0;
	endfunction

	function automatic void gov_write_reg(input logic [CFG_IDX_W-1:0] i,
			input logic [CFG_DATA_W-1:0] v);
		case (i)
			CFG_SMOOTHING_ALPHA: g_alpha = 64'(v[10:0]);
			CFG_TARGET_FPS:      g_fps = 64'(v[7:0]);
			CFG_DEGRADE_RATIO:   g_deg = 64'(v[9:0]);
			CFG_RECOVER_RATIO:   g_rec = 64'(v[9:0]);
			CFG_DEGRADE_HOLD:    g_dhold = 64'(v);
			CFG_RECOVER_HOLD:    g_rhold = 64'(v);
			default: ;
		endcase
	endfunction

	function automatic gov_result_t gov_predict(input req_t r);
		gov_result_t res;
		logic [63:0] f, a, dt, p0, p1, p2, big, second, sc;
		int th, cand, pc;
		bit cv, gv, cp, gp, auth;
		f = (g_fps == 0) ? 1 : g_fps;
		a = g_alpha;
		if (a < 1) a = 1;
		if (a > 1024) a = 1024;
		th = (r.thermal > 4) ? 4 : int'(r.thermal);
		dt = (r.delta > 250000) ? 250000 : 64'(r.delta);
		av_frame = ema(mx(r.cpu, r.gpu), a, av_frame);
		av_cpu = ema(r.cpu, a, av_cpu);
		av_gpu = ema(r.gpu, a, av_gpu);
		if (r.pvalid) begin
			av_pass[0] = ema(r.pre, a, av_pass[0]);
			av_pass[1] = ema(r.world, a, av_pass[1]);
			av_pass[2] = ema(r.comp, a, av_pass[2]);
		end
		av_itv = ema(r.itv, a, av_itv);

		cand = CLS_BALANCED;
		if (th >= 3) begin
			cand = CLS_THERMAL;
		end else begin
			cv = av_cpu > 0; gv = av_gpu > 0;
			cp = cv && over_period(av_cpu, f, 92, 100);
			gp = gv && over_period(av_gpu, f, 92, 100);
			if (gp && (!cp || av_gpu * 10 > av_cpu * 11)) cand = CLS_GPU;
			else if (cp && (!gp || av_cpu * 10 > av_gpu * 11)) cand = CLS_CPU;
			else if (av_itv > 0 && over_period(av_itv, f, 108, 100) &&
					(!cv || under_period(av_cpu, f, 82, 100)) &&
					(!gv || under_period(av_gpu, f, 82, 100))) cand = CLS_PACED;
		end
		if (cand == cls_pend) begin
			if (cls_hold < 255) cls_hold++;
		end else begin
			cls_pend = cand; cls_hold = 0;
		end
		if (cand == CLS_THERMAL || 64'(cls_hold) * 5 >= f) cls_now = cand;

		auth = r.pvalid && av_gpu > 0;
		pc = PASS_BALANCED;
		if (auth && over_period(av_gpu, f, 92, 100)) begin
			p0 = av_pass[0]; p1 = av_pass[1]; p2 = av_pass[2];
			big = mx(p0, mx(p1, p2));
			second = (p0 == big) ? mx(p1, p2) : (p1 == big) ? mx(p0, p2) : mx(p0, p1);
			if (big * 25 > second * 28 || big * 2 > av_gpu)
				pc = (big == p0) ? PASS_PRE : (big == p1) ? PASS_WORLD : PASS_COMP;
		end
		if (pc == pas_pend) begin
			if (pas_hold < 255) pas_hold++;
		end else begin
			pas_pend = pc; pas_hold = 0;
		end
		if (!auth) begin
			pas_now = 0; pas_pend = 0; pas_hold = 0;
		end else if (64'(pas_hold) * 5 >= f) begin
			pas_now = pc;
		end

		if (over_period(av_frame, f, g_deg, 256)) begin
			over_t = over_t + dt;
			if (over_t > 16777215) over_t = 16777215;
			recov_t = 0;
		end else if (av_frame > 0 && under_period(av_frame, f, g_rec, 256)) begin
			recov_t = recov_t + dt;
			if (recov_t > 16777215) recov_t = 16777215;
			over_t = 0;
		end else begin
			over_t = over_t > dt ? over_t - dt : 0;
			recov_t = recov_t > dt ? recov_t - dt : 0;
		end
		if (over_t >= g_dhold) begin
			if (g_level > 0) g_level--;
			over_t = 0; recov_t = 0;
		end else if (recov_t >= g_rhold) begin
			if (g_level < 3) g_level++;
			recov_t = 0;
		end
		if (th == 2 && g_level > 2) g_level = 2;
		else if (th == 3 && g_level > 1) g_level = 1;
		else if (th == 4) g_level = 0;

		case (g_level)
			0: sc = pct(90);
			1: sc = pct(94);
			2: sc = pct(97);
			default: sc = 1024;
		endcase
		if (cls_now == CLS_GPU && pas_now == PASS_COMP) begin
			sc = (sc * 9 + 5) / 10;
			if (sc < pct(60)) sc = pct(60);
		end
		if (th <= 1) begin
			if (sc < pct(90)) sc = pct(90);
		end else if (th == 2) begin
			if (sc > pct(90)) sc = pct(90);
		end else if (th == 3) begin
			if (sc > pct(84)) sc = pct(84);
		end else begin
			if (sc > pct(78)) sc = pct(78);
		end
		res.level = g_level[1:0];
		res.bclass = cls_now[2:0];
		res.pclass = pas_now[1:0];
		res.scale = sc[10:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// monitor
	always @(posedge clk) begin
		gov_result_t want;
		bit out_fire;
		in_fire = s_axis_tvalid && s_axis_tready;
		cfg_fire = cfg_valid && cfg_ready;
		out_fire = m_axis_tvalid && m_axis_tready;
		if (out_fire) begin
			n_results++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[1:0] !== want.level)
					report_mismatch("quality_level", m_axis_tdata[1:0], want.level);
				if (m_axis_tdata[4:2] !== want.bclass)
					report_mismatch("bottleneck_class", m_axis_tdata[4:2], want.bclass);
				if (m_axis_tdata[6:5] !== want.pclass)
					report_mismatch("pass_class", m_axis_tdata[6:5], want.pclass);
				if (m_axis_tdata[17:7] !== want.scale)
					report_mismatch("render_scale", m_axis_tdata[17:7], want.scale);
			end
		end
		if (in_fire) begin
			n_frames++;
			expected_results.push_back(gov_predict(cur_frame));
		end
		if (cfg_fire) begin
			n_cfg++;
			gov_write_reg(cur_cfg.idx, cur_cfg.val);
		end
		if (expected_results.size() == 0) quiet_cycles++;
		else quiet_cycles = 0;
		if (in_fire || cfg_fire || out_fire) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= 20000) begin
			$display("watchdog: no request moved for %0d cycles", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// driver
	always @(negedge clk) begin
		req_t r;
		logic nv, ncv;
		nv = 1'b0;
		ncv = 1'b0;
		if (arst_n) begin
			if (busy && ((s_axis_tvalid && in_fire) || (cfg_valid && cfg_fire)))
				busy = 0;
			if (busy) begin
				nv = s_axis_tvalid;
				ncv = cfg_valid;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reqs.size() != 0) begin
				r = pending_reqs[0];
				case (r.kind)
					REQ_FRAME: begin
						void'(pending_reqs.pop_front());
						cur_frame = r;
						s_axis_tdata <= {1'b0, r.delta, r.thermal, r.itv, r.comp, r.world,
							r.pre, r.gpu, r.cpu};
						s_axis_tuser <= r.pvalid;
						nv = 1'b1;
						busy = 1;
						burst_left--;
						if (burst_left <= 0) begin
							burst_left = $urandom_range(1, 24);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
						end
					end
					REQ_CFG: begin
						if (expected_results.size() == 0 && quiet_cycles >= 25) begin
							void'(pending_reqs.pop_front());
							cur_cfg = r;
							cfg_index <= r.idx;
							cfg_data <= r.val;
							ncv = 1'b1;
							busy = 1;
						end
					end
					default: begin
						if (expected_results.size() == 0) void'(pending_reqs.pop_front());
					end
				endcase
			end
		end
		s_axis_tvalid <= nv;
		cfg_valid <= ncv;
	end

	// receiver
	always @(negedge clk) begin
		logic rdy;
		int mode;
		rdy = 1'b0;
		if (arst_n) begin
			rx_cycle++;
			mode = (rx_cycle / 97) % 4;
			if (hold_off > 0) begin
				hold_off--;
			end else if (!hold_done && n_frames >= 700) begin
				hold_done = 1;
				hold_off = 400;
			end else begin
				case (mode)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 9) < 7);
					2: rdy = ($urandom_range(0, 9) < 3);
					default: rdy = (rx_cycle % 5 != 0);
				endcase
			end
		end
		m_axis_tready <= rdy;
	end

	function automatic req_t frame_req(input int cpu, gpu, pre, world, comp, itv,
			input int pv, th, dl);
		req_t r;
		r.kind = REQ_FRAME;
		r.cpu = 16'(cpu); r.gpu = 16'(gpu); r.pre = 16'(pre); r.world = 16'(world);
		r.comp = 16'(comp); r.itv = 16'(itv); r.pvalid = pv[0]; r.thermal = 3'(th);
		r.delta = 20'(dl);
		r.idx = '0; r.val = '0;
		return r;
	endfunction

	function automatic int clip16(input longint v);
		return (v > 65535) ? 65535 : int'(v);
	endfunction

	function automatic req_t random_frame(input int fps, input int load);
		req_t r;
		longint per, g;
		int w0, w1, w2, wsum, th, dl;
		per = 256000 / ((fps == 0) ? 1 : fps);
		if ($urandom_range(0, 99) < 12) begin
			r = frame_req($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 7),
				$urandom_range(0, 1048575));
			return r;
		end
		g = per * load * $urandom_range(85, 115) / 10000;
		w0 = $urandom_range(1, 10); w1 = $urandom_range(1, 10); w2 = $urandom_range(1, 10);
		if ($urandom_range(0, 3) == 0) w2 = w2 * 4;
		wsum = w0 + w1 + w2;
		th = $urandom_range(0, 99);
		th = (th < 70) ? $urandom_range(0, 1) : (th < 85) ? 2 : (th < 92) ? 3 :
			(th < 97) ? 4 : $urandom_range(5, 7);
		dl = int'(1000000 / ((fps == 0) ? 1 : fps)) + $urandom_range(0, 2000) - 1000;
		if (dl < 0) dl = 0;
		if ($urandom_range(0, 19) == 0) dl = $urandom_range(0, 1048575);
		r = frame_req(clip16(per * load * $urandom_range(80, 120) / 10000), clip16(g),
			clip16(g * w0 / wsum), clip16(g * w1 / wsum), clip16(g * w2 / wsum),
			clip16(per * $urandom_range(80, 140) / 100),
			($urandom_range(0, 9) != 0), th, (dl > 1048575) ? 1048575 : dl);
		if ($urandom_range(0, 9) == 0) r.cpu = 0;
		if ($urandom_range(0, 9) == 0) r.gpu = 0;
		if ($urandom_range(0, 14) == 0) r.itv = 0;
		return r;
	endfunction

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] i, input int v);
		req_t r;
		r = frame_req(0, 0, 0, 0, 0, 0, 0, 0, 0);
		r.kind = REQ_CFG;
		r.idx = i;
		r.val = CFG_DATA_W'(v);
		pending_reqs.push_back(r);
	endtask

	task automatic push_drain();
		req_t r;
		r = frame_req(0, 0, 0, 0, 0, 0, 0, 0, 0);
		r.kind = REQ_DRAIN;
		pending_reqs.push_back(r);
	endtask

	int ph_alpha[8] = '{1024, 1, 0, 2047, 512, 300, 102, 700};
	int ph_fps[8]   = '{60, 240, 1, 0, 30, 120, 144, 255};
	int ph_deg[8]   = '{269, 0, 1023, 256, 300, 200, 269, 512};
	int ph_rec[8]   = '{218, 1023, 0, 200, 230, 250, 218, 100};
	int ph_dhold[8] = '{0, 100000, 16777215, 30000, 50000, 0, 200000, 20000};
	int ph_rhold[8] = '{0, 200000, 16777215, 50000, 100000, 30000, 16777215, 0};

	initial begin
		int load, wait_n;
		gov_reset_model();

		// directed frames under reset settings
		pending_reqs.push_back(frame_req(0, 0, 0, 0, 0, 0, 0, TH_NOMINAL, 0));
		pending_reqs.push_back(frame_req(65535, 65535, 65535, 65535, 65535, 65535, 1, 7,
			1048575));
		pending_reqs.push_back(frame_req(1, 1, 1, 1, 1, 1, 1, TH_NOMINAL, 1));
		for (int t = 0; t < 8; t++)
			pending_reqs.push_back(frame_req(4300, 4400, 1000, 1000, 1000, 4300, 1, t,
				16667));
		// pass tie, then a dominant composite pass
		for (int k = 0; k < 4; k++)
			pending_reqs.push_back(frame_req(2000, 6000, 2000, 2000, 2000, 4300, 1,
				TH_NOMINAL, 250001));
		for (int k = 0; k < 4; k++)
			pending_reqs.push_back(frame_req(2000, 6000, 500, 1000, 4500, 4300, 1,
				TH_LIGHT, 16667));
		// frame paced: long interval, light cpu and gpu
		pending_reqs.push_back(frame_req(1000, 1000, 300, 300, 300, 9000, 0, TH_NOMINAL,
			16667));
		pending_reqs.push_back(frame_req(6000, 0, 0, 0, 0, 0, 0, TH_NOMINAL, 16667));
		pending_reqs.push_back(frame_req(0, 6000, 0, 0, 0, 0, 1, TH_NOMINAL, 16667));
		push_drain();

		for (int p = 0; p < 8; p++) begin
			push_cfg(CFG_SMOOTHING_ALPHA, ph_alpha[p]);
			push_cfg(CFG_TARGET_FPS, ph_fps[p]);
			push_cfg(CFG_DEGRADE_RATIO, ph_deg[p]);
			push_cfg(CFG_RECOVER_RATIO, ph_rec[p]);
			push_cfg(CFG_DEGRADE_HOLD, ph_dhold[p]);
			push_cfg(CFG_RECOVER_HOLD, ph_rhold[p]);
			load = 100;
			for (int k = 0; k < 166; k++) begin
				if (k % 30 == 0) load = $urandom_range(50, 150);
				pending_reqs.push_back(random_frame(ph_fps[p], load));
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_reqs.size() == 0 && !busy);
		wait_n = 0;
		while (expected_results.size() != 0 && wait_n < 100000) begin
			@(posedge clk);
			wait_n++;
		end
		repeat (40) @(posedge clk);
		$display("run covered %0d frame requests, %0d results, %0d register writes",
			n_frames, n_results, n_cfg);
		$display("eight register settings incl. extremes, thermal codes 0..7, output stalls");
		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", n_errors, expected_results.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/fgov_pkg.sv
hdl/fgov_ctrl.sv
hdl/fgov_dp.sv
hdl/frame_time_quality_governor_unit.sv
tb/sv/frame_time_quality_governor_unit_tb.sv
